// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

    // Input request codes.
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    // Result descriptor codes.
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_LAST  = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] CFG_FILE_SIZE     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  WINDOW_SIZE_RST   = 8'd5;
    localparam logic [23:0] FILE_SIZE_RST     = 24'd0;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    // Highest usable sequence number for the last data packet.
    localparam logic [15:0] SEQ_CAP = 16'hFFFE;
    localparam logic [15:0] SEQ_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/go_back_n_send_window.sv =====
// A request is held in the input register, and its result then in the result register.
// Throughput: one request per cycle while the result is not stalled; the window, offset and timer logic runs in
// a single pass between the input register and the result register.
// The stall toward the requester only rises while a result is held by a stall.
// Synchronous active-low reset returns the window state to idle, clears both valid flags
// and loads the configuration registers with their defaults.
module go_back_n_send_window #(
    parameter int PAYLOAD_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_ack_number,
    input  logic        i_ack_good,
    input  logic [7:0]  i_name_length,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_seq_out,
    output logic [23:0] o_byte_offset,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_window_base
);

    localparam logic [15:0] PAY16 = 16'(PAYLOAD_BYTES);

    // Configuration registers.
    logic [7:0]  r_window_size;
    logic [23:0] r_file_size;
    logic [15:0] r_timeout_ticks;

    // Input register.
    logic             r_in_valid;
    gbn_pkg::t_action r_action;
    logic [15:0]      r_ack_number;
    logic             r_ack_good;
    logic [7:0]       r_name_length;

    // Window state.
    logic [15:0] r_base_seq, n_base_seq;
    logic [15:0] r_next_seq, n_next_seq;
    logic [15:0] r_idle_timer, n_idle_timer;
    logic        r_active, n_active;

    // Result register.
    logic           r_out_valid;
    gbn_pkg::t_kind r_kind;
    logic [15:0]    r_seq_out;
    logic [23:0]    r_byte_offset;
    logic [15:0]    r_payload_length;
    logic [15:0]    r_window_base;

    logic           n_emit;
    gbn_pkg::t_kind n_kind;
    logic [15:0]    n_seq_out;
    logic [23:0]    n_byte_offset;
    logic [15:0]    n_payload_length;

    logic        proc_en;
    logic [15:0] seq_m1;
    logic [31:0] next_off;
    logic        send_fits;
    logic        win_ok;
    logic [23:0] remain;
    logic        is_last;
    logic [15:0] len_last;
    logic [15:0] ack_base;
    logic [15:0] base_m1;
    logic [31:0] base_off;
    logic        done;
    logic [15:0] tick_val;
    logic        timeout;

    // The held request moves on whenever the result slot is free or draining.
    assign proc_en    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_en;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= gbn_pkg::WINDOW_SIZE_RST;
            r_file_size     <= gbn_pkg::FILE_SIZE_RST;
            r_timeout_ticks <= gbn_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gbn_pkg::CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[7:0];
                gbn_pkg::CFG_FILE_SIZE:     r_file_size     <= i_cfg_data;
                gbn_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action      <= gbn_pkg::t_action'(i_action);
            r_ack_number  <= i_ack_number;
            r_ack_good    <= i_ack_good;
            r_name_length <= i_name_length;
        end
    end

    // Send slot checks. A sequence s is within the file when (s-1)*P <= file size,
    // which replaces a division of the file size by the payload size.
    always_comb begin
        seq_m1    = r_next_seq - 16'd1;
        next_off  = 32'(seq_m1) * 32'(PAY16);
        send_fits = (r_next_seq == 16'd0) ||
                    ((r_next_seq != gbn_pkg::SEQ_MAX) && (next_off <= 32'(r_file_size)));
        win_ok    = 17'(r_next_seq) < (17'(r_base_seq) + 17'(r_window_size));
        remain    = r_file_size - next_off[23:0];
        is_last   = (r_next_seq == gbn_pkg::SEQ_CAP) || (remain < 24'(PAY16));
        len_last  = (remain[23:16] != 8'd0) ? gbn_pkg::SEQ_MAX : remain[15:0];
    end

    // Acknowledgement checks: the base passes the last packet when
    // (base-1)*P exceeds the file size or the base is beyond the cap.
    always_comb begin
        ack_base = (r_ack_good && (r_ack_number > r_base_seq)) ? r_ack_number : r_base_seq;
        base_m1  = ack_base - 16'd1;
        base_off = 32'(base_m1) * 32'(PAY16);
        done     = (ack_base != 16'd0) &&
                   ((ack_base == gbn_pkg::SEQ_MAX) || (base_off > 32'(r_file_size)));
    end

    // Tick checks with a saturating timer.
    always_comb begin
        tick_val = (r_idle_timer == gbn_pkg::SEQ_MAX) ? gbn_pkg::SEQ_MAX
                                                        : r_idle_timer + 16'd1;
        timeout  = tick_val >= r_timeout_ticks;
    end

    // Request decode: next window state and the result descriptor.
    always_comb begin
        n_base_seq       = r_base_seq;
        n_next_seq       = r_next_seq;
        n_idle_timer     = r_idle_timer;
        n_active         = r_active;
        n_emit           = 1'b0;
        n_kind           = gbn_pkg::KIND_DATA;
        n_seq_out        = r_next_seq;
        n_byte_offset    = next_off[23:0];
        n_payload_length = PAY16;
        unique case (r_action)
            gbn_pkg::ACT_START: begin
                n_active         = 1'b1;
                n_base_seq       = 16'd0;
                n_next_seq       = 16'd1;
                n_idle_timer     = 16'd0;
                n_emit           = 1'b1;
                n_kind           = gbn_pkg::KIND_START;
                n_seq_out        = 16'd0;
                n_byte_offset    = 24'd0;
                n_payload_length = 16'(r_name_length);
            end
            gbn_pkg::ACT_SEND: begin
                if (r_active && send_fits && win_ok) begin
                    n_emit     = 1'b1;
                    n_next_seq = r_next_seq + 16'd1;
                    if (r_next_seq == 16'd0) begin
                        // A go-back to zero re-issues the start descriptor.
                        n_kind           = gbn_pkg::KIND_START;
                        n_byte_offset    = 24'd0;
                        n_payload_length = 16'(r_name_length);
                    end else if (is_last) begin
                        n_kind           = gbn_pkg::KIND_LAST;
                        n_payload_length = len_last;
                    end
                end
            end
            gbn_pkg::ACT_ACK: begin
                if (r_active) begin
                    n_idle_timer = 16'd0;
                    n_base_seq   = ack_base;
                    if (done) begin
                        n_active         = 1'b0;
                        n_emit           = 1'b1;
                        n_kind           = gbn_pkg::KIND_DONE;
                        n_seq_out        = ack_base;
                        n_byte_offset    = 24'd0;
                        n_payload_length = 16'd0;
                    end
                end
            end
            gbn_pkg::ACT_TICK: begin
                if (r_active) begin
                    if (timeout) begin
                        n_next_seq   = r_base_seq;
                        n_idle_timer = 16'd0;
                    end else begin
                        n_idle_timer = tick_val;
                    end
                end
            end
            default: ;
        endcase
    end

    // Window state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seq   <= 16'd0;
            r_next_seq   <= 16'd1;
            r_idle_timer <= 16'd0;
            r_active     <= 1'b0;
        end else if (proc_en) begin
            r_base_seq   <= n_base_seq;
            r_next_seq   <= n_next_seq;
            r_idle_timer <= n_idle_timer;
            r_active     <= n_active;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && n_emit) begin
            r_kind           <= n_kind;
            r_seq_out        <= n_seq_out;
            r_byte_offset    <= n_byte_offset;
            r_payload_length <= n_payload_length;
            r_window_base    <= n_base_seq;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_seq_out        = r_seq_out;
    assign o_byte_offset    = r_byte_offset;
    assign o_payload_length = r_payload_length;
    assign o_window_base    = r_window_base;

endmodule

// ===== hw/rtl/gbn_checker.sv =====
module gbn_checker #(
    parameter int PAYLOAD_BYTES = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_seq_out,
    input logic [23:0] o_byte_offset,
    input logic [15:0] o_payload_length,
    input logic [15:0] o_window_base
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its descriptor.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_kind) && $stable(o_seq_out) &&
            $stable(o_byte_offset) && $stable(o_payload_length) && $stable(o_window_base))
        else $error("stalled result changed");

    // The done report carries the new base and no payload.
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gbn_pkg::KIND_DONE) |->
            (o_seq_out == o_window_base) && (o_byte_offset == 24'd0) &&
            (o_payload_length == 16'd0) && (o_seq_out != 16'd0))
        else $error("malformed done report");

    // A start descriptor is sequence zero with a file name length.
    a_start_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gbn_pkg::KIND_START) |->
            (o_seq_out == 16'd0) && (o_byte_offset == 24'd0) &&
            (o_payload_length[15:8] == 8'd0))
        else $error("malformed start descriptor");

    // A middle data packet is full sized and never sequence zero.
    a_data_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gbn_pkg::KIND_DATA) |->
            (o_payload_length == 16'(PAYLOAD_BYTES)) && (o_seq_out != 16'd0))
        else $error("malformed data descriptor");

endmodule

bind go_back_n_send_window gbn_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_gbn_checker (.*);

// ===== verif/tb.sv =====
module tb;

    localparam int PAYLOAD_BYTES = 1024;
    localparam int STALL_PCT     = 24;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int DRAIN_CYCLES  = 6;

    // One request toward the window controller.
    typedef struct {
        gbn_pkg::t_action action;
        logic [15:0]      ack_number;
        logic             ack_good;
        logic [7:0]       name_length;
    } t_req;

    // One packet descriptor from the window controller.
    typedef struct {
        gbn_pkg::t_kind kind;
        logic [15:0]    seq;
        logic [23:0]    offset;
        logic [15:0]    length;
        logic [15:0]    base;
    } t_desc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = gbn_pkg::CFG_WINDOW_SIZE;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = gbn_pkg::ACT_TICK;
    logic [15:0] i_ack_number = '0;
    logic        i_ack_good = 1'b0;
    logic [7:0]  i_name_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_seq_out;
    logic [23:0] o_byte_offset;
    logic [15:0] o_payload_length;
    logic [15:0] o_window_base;

    go_back_n_send_window #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_ack_number     (i_ack_number),
        .i_ack_good       (i_ack_good),
        .i_name_length    (i_name_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_seq_out        (o_seq_out),
        .o_byte_offset    (o_byte_offset),
        .o_payload_length (o_payload_length),
        .o_window_base    (o_window_base)
    );

    // Requests waiting for the driver and descriptors waiting for the DUT.
    t_req  pending_reqs[$];
    t_desc expected_descs[$];

    // Shadow copy of the configuration registers.
    int cfg_window  = gbn_pkg::WINDOW_SIZE_RST;
    int cfg_fsize   = gbn_pkg::FILE_SIZE_RST;
    int cfg_timeout = gbn_pkg::TIMEOUT_TICKS_RST;

    // Shadow copy of the sender window state.
    int  base_seq  = 0;
    int  next_seq  = 1;
    int  idle_tmr  = 0;
    bit  xfer_on   = 1'b0;

    int  mismatches = 0;
    int  accepted_reqs = 0;
    int  quiet_cycles = 0;
    bit  calm;
    t_req cur_req;

    // No idling on either side for a stretch in the middle of the run.
    assign calm = (accepted_reqs >= 400) && (accepted_reqs < 600);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Number of the last data packet for the current file size.
    function automatic int last_packet_num();
        int n;
        n = cfg_fsize / PAYLOAD_BYTES + 1;
        return (n > gbn_pkg::SEQ_CAP) ? int'(gbn_pkg::SEQ_CAP) : n;
    endfunction

    // Advance the shadow window by one request and queue the descriptor it yields.
    task automatic advance_window(input t_req rq);
        t_desc d;
        int    last;
        int    seq;
        int    off;
        int    len;
        int    t;
        last = last_packet_num();
        if (rq.action == gbn_pkg::ACT_START) begin
            xfer_on  = 1'b1;
            base_seq = 0;
            next_seq = 1;
            idle_tmr = 0;
            d = '{gbn_pkg::KIND_START, 16'd0, 24'd0, 16'(rq.name_length), 16'd0};
            expected_descs.push_back(d);
        end else if (xfer_on) begin
            case (rq.action)
                gbn_pkg::ACT_SEND: begin
                    if (next_seq <= last && next_seq < base_seq + cfg_window) begin
                        seq = next_seq;
                        if (seq == 0) begin
                            // Going back to zero re-issues the start descriptor.
                            d = '{gbn_pkg::KIND_START, 16'd0, 24'd0, 16'(rq.name_length),
                                  16'(base_seq)};
                        end else begin
                            off = (seq - 1) * PAYLOAD_BYTES;
                            if (seq == last) begin
                                len = (cfg_fsize >= off) ? cfg_fsize - off : 0;
                                if (len > gbn_pkg::SEQ_MAX) len = gbn_pkg::SEQ_MAX;
                                d = '{gbn_pkg::KIND_LAST, 16'(seq), 24'(off), 16'(len),
                                      16'(base_seq)};
                            end else begin
                                d = '{gbn_pkg::KIND_DATA, 16'(seq), 24'(off),
                                      16'(PAYLOAD_BYTES), 16'(base_seq)};
                            end
                        end
                        expected_descs.push_back(d);
                        next_seq = (seq + 1) & 16'hFFFF;
                    end
                end
                gbn_pkg::ACT_ACK: begin
                    idle_tmr = 0;
                    if (rq.ack_good && int'(rq.ack_number) > base_seq)
                        base_seq = rq.ack_number;
                    if (base_seq > last) begin
                        xfer_on = 1'b0;
                        d = '{gbn_pkg::KIND_DONE, 16'(base_seq), 24'd0, 16'd0,
                              16'(base_seq)};
                        expected_descs.push_back(d);
                    end
                end
                default: begin
                    t = (idle_tmr < gbn_pkg::SEQ_MAX) ? idle_tmr + 1
                                                      : int'(gbn_pkg::SEQ_MAX);
                    if (t >= cfg_timeout) begin
                        next_seq = base_seq;
                        idle_tmr = 0;
                    end else begin
                        idle_tmr = t;
                    end
                end
            endcase
        end
    endtask

    // Driver: present queued requests, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_window(cur_req);
                accepted_reqs++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
                    cur_req = pending_reqs.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= cur_req.action;
                    i_ack_number  <= cur_req.ack_number;
                    i_ack_good    <= cur_req.ack_good;
                    i_name_length <= cur_req.name_length;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare against the oldest descriptor.
    always @(posedge i_clk) begin
        t_desc d;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_descs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected descriptor: kind %0d seq %0d off %0d len %0d",
                                 o_kind, o_seq_out, o_byte_offset, o_payload_length,
                                 " base %0d", o_window_base);
                end else begin
                    d = expected_descs.pop_front();
                    if (o_kind !== d.kind || o_seq_out !== d.seq ||
                        o_byte_offset !== d.offset || o_payload_length !== d.length ||
                        o_window_base !== d.base) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp kind %0d seq %0d off %0d len %0d base %0d",
                                     d.kind, d.seq, d.offset, d.length, d.base);
                            $display("          got kind %0d seq %0d off %0d len %0d base %0d",
                                     o_kind, o_seq_out, o_byte_offset, o_payload_length,
                                     o_window_base);
                        end
                    end
                end
            end
            i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // Watchdog on cycles where neither channel moves a request or a descriptor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic add_req(input gbn_pkg::t_action act, input int ack, input bit good,
                           input int nlen);
        t_req rq;
        rq = '{act, 16'(ack), good, 8'(nlen)};
        pending_reqs.push_back(rq);
    endtask

    // Wait until every request is taken and every descriptor has come back.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid || expected_descs.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges while the block is idle.
    task automatic set_window_config(input int win, input int fsize, input int tmo);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gbn_pkg::CFG_WINDOW_SIZE;
        i_cfg_data  <= 24'(win & 8'hFF);
        @(posedge i_clk);
        i_cfg_index <= gbn_pkg::CFG_FILE_SIZE;
        i_cfg_data  <= 24'(fsize);
        @(posedge i_clk);
        i_cfg_index <= gbn_pkg::CFG_TIMEOUT_TICKS;
        i_cfg_data  <= 24'(tmo & 16'hFFFF);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_window  = win & 8'hFF;
        cfg_fsize   = fsize & 24'hFFFFFF;
        cfg_timeout = tmo & 16'hFFFF;
    endtask

    // Mostly well-formed transfers with random content, plus noise.
    task automatic gen_traffic(input int count);
        int  ack_guess;
        int  r;
        int  a;
        bit  good;
        bit  need_start;
        need_start = 1'b1;
        ack_guess  = 0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (need_start || r < 3) begin
                add_req(gbn_pkg::ACT_START, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 255));
                ack_guess  = 0;
                need_start = 1'b0;
            end else if (r < 48) begin
                add_req(gbn_pkg::ACT_SEND, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 255));
            end else if (r < 73) begin
                a    = (ack_guess + $urandom_range(0, 3)) & 16'hFFFF;
                good = ($urandom_range(0, 9) != 0);
                add_req(gbn_pkg::ACT_ACK, a, good, $urandom_range(0, 255));
                if (good && a > ack_guess) ack_guess = a;
                // Once the whole file is acknowledged, open the next transfer.
                if (ack_guess > last_packet_num()) need_start = 1'b1;
            end else if (r < 88) begin
                add_req(gbn_pkg::ACT_TICK, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 255));
            end else begin
                add_req(gbn_pkg::t_action'($urandom_range(1, 3)), $urandom,
                        $urandom_range(0, 1), $urandom_range(0, 255));
            end
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        int w;
        int f;
        int t;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: three packets, window of two, timeout after two ticks.
        set_window_config(2, 2500, 2);
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);            // ignored while idle
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // ignored while idle
        add_req(gbn_pkg::ACT_START, 0, 0, 0);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // seq 1
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // window full
        add_req(gbn_pkg::ACT_ACK, 3, 0, 0);             // bad checksum: timer only
        add_req(gbn_pkg::ACT_ACK, 1, 1, 0);             // slide to 1
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // seq 2
        add_req(gbn_pkg::ACT_ACK, 1, 1, 0);             // duplicate
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);            // timeout: back to 1
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);
        add_req(gbn_pkg::ACT_ACK, 0, 1, 0);             // older than base
        add_req(gbn_pkg::ACT_ACK, 3, 1, 0);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // last packet
        add_req(gbn_pkg::ACT_ACK, 4, 1, 0);             // done
        add_req(gbn_pkg::ACT_START, 16'hFFFF, 1, 255);
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);            // go back to zero
        add_req(gbn_pkg::ACT_SEND, 0, 1, 8'hAA);        // start descriptor again
        add_req(gbn_pkg::ACT_START, 0, 0, 8'h55);       // restart while active
        add_req(gbn_pkg::ACT_ACK, 16'hFFFF, 1, 0);      // done at top sequence number
        wait_drained();

        // Directed: empty file, widest window, timeout of one tick.
        set_window_config(255, 0, 1);
        add_req(gbn_pkg::ACT_START, 0, 0, 7);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);            // last packet with zero length
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 3);
        add_req(gbn_pkg::ACT_ACK, 2, 1, 0);
        wait_drained();

        // Directed: zero window and zero timeout.
        set_window_config(0, 5000, 0);
        add_req(gbn_pkg::ACT_START, 0, 0, 1);
        add_req(gbn_pkg::ACT_SEND, 0, 0, 0);
        add_req(gbn_pkg::ACT_TICK, 0, 0, 0);
        wait_drained();

        // Random phases, the first one at the largest file and timeout.
        for (int p = 0; p < 9; p++) begin
            if (p == 0) begin
                w = 1;
                f = 24'hFFFFFF;
                t = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 9))
                    0:       w = 255;
                    1:       w = 1;
                    default: w = $urandom_range(1, 8);
                endcase
                f = ($urandom_range(0, 9) == 0) ? int'($urandom & 24'hFFFFFF)
                                                : int'($urandom_range(0, 10240));
                t = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(1, 6));
            end
            set_window_config(w, f, t);
            gen_traffic(p == 0 ? 60 : 110);
            wait_drained();
        end

        if (mismatches == 0 && expected_descs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
